@@ rtl/lcbc_pkg.sv @@
`default_nettype none

package lcbc_pkg;

  // key codes
  localparam logic [7:0] KeyRed     = 8'h01;
  localparam logic [7:0] KeyGreen   = 8'h02;
  localparam logic [7:0] KeyBlue    = 8'h03;
  localparam logic [7:0] KeyWhite   = 8'h04;
  localparam logic [7:0] KeyPlus    = 8'h20;
  localparam logic [7:0] KeyMinus   = 8'h10;
  localparam logic [7:0] KeyOff     = 8'h3f;
  localparam logic [7:0] KeyTimeout = 8'hff;

  // selected colour codes
  localparam logic [2:0] ColNone  = 3'd0;
  localparam logic [2:0] ColRed   = 3'd1;
  localparam logic [2:0] ColGreen = 3'd2;
  localparam logic [2:0] ColBlue  = 3'd3;
  localparam logic [2:0] ColWhite = 3'd4;

  localparam logic [7:0] RedPreset      = 8'd47;
  localparam logic [7:0] OtherPreset    = 8'd111;
  localparam logic [7:0] ResetRedDuty   = 8'd47;
  localparam logic [7:0] ResetOtherDuty = 8'd95;
  localparam logic [7:0] IdleLimit      = 8'd30;

  localparam int unsigned CfgIdxW = 4;

  typedef enum logic [CfgIdxW-1:0] {
    CfgRedMax   = 4'd0,
    CfgRedMin   = 4'd1,
    CfgGreenMax = 4'd2,
    CfgGreenMin = 4'd3,
    CfgBlueMax  = 4'd4,
    CfgBlueMin  = 4'd5,
    CfgWhiteMin = 4'd6,
    CfgStep     = 4'd7
  } cfg_idx_e;

  localparam logic [7:0] RstRedMax   = 8'd127;
  localparam logic [7:0] RstRedMin   = 8'd15;
  localparam logic [7:0] RstGreenMax = 8'd200;
  localparam logic [7:0] RstGreenMin = 8'd15;
  localparam logic [7:0] RstBlueMax  = 8'd200;
  localparam logic [7:0] RstBlueMin  = 8'd15;
  localparam logic [7:0] RstWhiteMin = 8'd15;
  localparam logic [7:0] RstStep     = 8'd16;

endpackage

`default_nettype wire

@@ rtl/lamp_color_brightness_controller.sv @@
// The result word is registered from each accepted key word.
// Throughput: one word per cycle; the result register is the only stage, and the
// input stalls only while a result is held by a stalled output.
// Reset (async, active low): no colour, lamps dark, duty 0, fan off, PWM running,
// colour duties red 47 / others 95, limits and step at their reset values.
// The configuration port is always ready.
`default_nettype none

module lamp_color_brightness_controller (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // config write channel
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [lcbc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [7:0]                     cfg_data_i,
  // key input channel
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [7:0]                     command_i,
  input  wire logic [7:0]                     idle_seconds_i,
  // result channel
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic [3:0]                          lamp_enables_o,
  output logic [7:0]                          pwm_duty_o,
  output logic                                pwm_running_o,
  output logic                                fan_request_o,
  output logic                                restart_idle_timer_o
);

  // configuration registers
  logic [7:0] red_max_q, red_min_q, green_max_q, green_min_q;
  logic [7:0] blue_max_q, blue_min_q, white_min_q, step_q;

  // block state
  logic [2:0] sel_q, sel_d;
  logic       lit_q, lit_d;
  logic [7:0] duty_q [4];
  logic [3:0] lamp_q, lamp_d;
  logic [7:0] cur_q, cur_d;
  logic       fan_q, fan_d;
  logic       pwm_on_q, pwm_on_d;
  logic       restart_q, restart_d;
  logic       out_valid_q;

  logic       in_accept;
  logic       duty_we;
  logic [1:0] duty_widx;
  logic [7:0] duty_wdata;

  // adjust path
  logic [1:0] sel_idx;
  logic [7:0] sel_duty;
  logic [7:0] hi, lo;
  logic [8:0] sum;
  logic [7:0] diff;
  logic [7:0] up_duty, dn_duty;
  logic       sel_valid;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_accept   = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_max_q   <= lcbc_pkg::RstRedMax;
      red_min_q   <= lcbc_pkg::RstRedMin;
      green_max_q <= lcbc_pkg::RstGreenMax;
      green_min_q <= lcbc_pkg::RstGreenMin;
      blue_max_q  <= lcbc_pkg::RstBlueMax;
      blue_min_q  <= lcbc_pkg::RstBlueMin;
      white_min_q <= lcbc_pkg::RstWhiteMin;
      step_q      <= lcbc_pkg::RstStep;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        lcbc_pkg::CfgRedMax:   red_max_q   <= cfg_data_i;
        lcbc_pkg::CfgRedMin:   red_min_q   <= cfg_data_i;
        lcbc_pkg::CfgGreenMax: green_max_q <= cfg_data_i;
        lcbc_pkg::CfgGreenMin: green_min_q <= cfg_data_i;
        lcbc_pkg::CfgBlueMax:  blue_max_q  <= cfg_data_i;
        lcbc_pkg::CfgBlueMin:  blue_min_q  <= cfg_data_i;
        lcbc_pkg::CfgWhiteMin: white_min_q <= cfg_data_i;
        lcbc_pkg::CfgStep:     step_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // limits and saturating step for the selected colour
  assign sel_valid = (sel_q >= lcbc_pkg::ColRed) && (sel_q <= lcbc_pkg::ColWhite);
  assign sel_idx   = 2'(sel_q - 3'd1);
  assign sel_duty  = duty_q[sel_idx];

  always_comb begin
    case (sel_q)
      lcbc_pkg::ColRed:  hi = red_max_q;
      lcbc_pkg::ColBlue: hi = blue_max_q;
      default:           hi = green_max_q;  // white shares green's ceiling
    endcase
    case (sel_q)
      lcbc_pkg::ColRed:   lo = red_min_q;
      lcbc_pkg::ColGreen: lo = green_min_q;
      lcbc_pkg::ColBlue:  lo = blue_min_q;
      default:            lo = white_min_q;
    endcase
  end

  assign sum     = {1'b0, sel_duty} + {1'b0, step_q};
  assign diff    = sel_duty - step_q;
  assign up_duty = (sum > {1'b0, hi}) ? hi : sum[7:0];
  assign dn_duty = ((sel_duty < step_q) || (diff < lo)) ? lo : diff;

  always_comb begin
    sel_d      = sel_q;
    lit_d      = lit_q;
    lamp_d     = lamp_q;
    cur_d      = cur_q;
    fan_d      = fan_q;
    pwm_on_d   = pwm_on_q;
    restart_d  = 1'b0;
    duty_we    = 1'b0;
    duty_widx  = sel_idx;
    duty_wdata = lcbc_pkg::OtherPreset;
    unique case (command_i) inside
      lcbc_pkg::KeyRed, lcbc_pkg::KeyGreen, lcbc_pkg::KeyBlue, lcbc_pkg::KeyWhite: begin
        sel_d      = command_i[2:0];
        lit_d      = 1'b1;
        duty_we    = 1'b1;
        duty_widx  = 2'(command_i[2:0] - 3'd1);
        duty_wdata = (command_i == lcbc_pkg::KeyRed) ? lcbc_pkg::RedPreset
                                                     : lcbc_pkg::OtherPreset;
        cur_d      = duty_wdata;
        // red clears the other lamps first
        lamp_d     = ((command_i == lcbc_pkg::KeyRed) ? 4'b0000 : lamp_q)
                     | (4'b0001 << duty_widx);
        fan_d      = 1'b1;
        restart_d  = 1'b1;
      end
      lcbc_pkg::KeyPlus, lcbc_pkg::KeyMinus: begin
        if (lit_q) begin
          if (sel_valid) begin
            duty_we    = 1'b1;
            duty_wdata = (command_i == lcbc_pkg::KeyPlus) ? up_duty : dn_duty;
            cur_d      = duty_wdata;
            lamp_d     = 4'b0001 << sel_idx;
          end
          fan_d     = 1'b1;
          restart_d = 1'b1;
        end
      end
      lcbc_pkg::KeyOff: begin
        sel_d  = lcbc_pkg::ColNone;
        lit_d  = 1'b0;
        lamp_d = 4'b0000;
        cur_d  = 8'd0;
        if (idle_seconds_i > lcbc_pkg::IdleLimit) begin
          fan_d = 1'b0;
        end
      end
      lcbc_pkg::KeyTimeout: begin
        sel_d    = lcbc_pkg::ColNone;
        lit_d    = 1'b0;
        lamp_d   = 4'b0000;
        cur_d    = 8'd0;
        fan_d    = 1'b0;
        pwm_on_d = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q     <= lcbc_pkg::ColNone;
      lit_q     <= 1'b0;
      duty_q[0] <= lcbc_pkg::ResetRedDuty;
      duty_q[1] <= lcbc_pkg::ResetOtherDuty;
      duty_q[2] <= lcbc_pkg::ResetOtherDuty;
      duty_q[3] <= lcbc_pkg::ResetOtherDuty;
      lamp_q    <= 4'b0000;
      cur_q     <= 8'd0;
      fan_q     <= 1'b0;
      pwm_on_q  <= 1'b1;
      restart_q <= 1'b0;
    end else if (in_accept) begin
      sel_q     <= sel_d;
      lit_q     <= lit_d;
      lamp_q    <= lamp_d;
      cur_q     <= cur_d;
      fan_q     <= fan_d;
      pwm_on_q  <= pwm_on_d;
      restart_q <= restart_d;
      if (duty_we) begin
        duty_q[duty_widx] <= duty_wdata;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result word mirrors the state left by the last accepted key
  assign out_valid_o          = out_valid_q;
  assign lamp_enables_o       = lamp_q;
  assign pwm_duty_o           = cur_q;
  assign pwm_running_o        = pwm_on_q;
  assign fan_request_o        = fan_q;
  assign restart_idle_timer_o = restart_q;

  a_red_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && (command_i == lcbc_pkg::KeyRed) |=> lamp_enables_o == 4'b0001)
    else $error("red key must leave only the red lamp on");

  a_timeout_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && (command_i == lcbc_pkg::KeyTimeout)
    |=> out_valid_o && !pwm_running_o && !fan_request_o && (lamp_enables_o == 4'b0000))
    else $error("timeout off must stop pwm, fan and lamps");

  a_pwm_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$rose(pwm_on_q))
    else $error("pwm restarted without reset");

  a_lit_has_colour: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lit_q |-> sel_valid)
    else $error("lit with no colour selected");

  a_unlit_step_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && !lit_q && ((command_i == lcbc_pkg::KeyPlus) ||
    (command_i == lcbc_pkg::KeyMinus)) |=> !restart_idle_timer_o && $stable(pwm_duty_o))
    else $error("plus/minus while dark changed state");

endmodule

`default_nettype wire
